/* rtl/core/csu_pkg.sv */
// Shared types and constants for the cosine similarity unit.
// Depends on nothing; every other file in rtl/core imports it.
`default_nettype none

package csu_pkg;

  // Element, accumulator and result widths, plus product and search constants
  localparam int unsigned ElemW   = 16;
  localparam int unsigned AccW    = 48;
  localparam int unsigned SimW    = 16;
  localparam int unsigned QW      = 15;
  localparam int unsigned ProdW   = 128;
  localparam int unsigned SqPW    = 96;
  localparam int unsigned MW      = 30;
  localparam int unsigned SimOne  = 16384;
  localparam int unsigned RoundSh = 30;

  typedef struct packed {
    logic signed [ElemW-1:0] first_element;
    logic signed [ElemW-1:0] second_element;
    logic                    last_element;
  } in_t;

  typedef struct packed {
    logic signed [SimW-1:0] similarity;
    logic                   zero_norm;
  } out_t;

  // Operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MUL_SQ_PROD  = 2'd0,
    MUL_DOT_SQ   = 2'd1,
    MUL_TRIAL    = 2'd2
  } mul_op_e;

  typedef struct packed {
    logic    acc_en;
    logic    latch;
    logic    mul_start;
    mul_op_e mul_op;
    logic    store_p;
    logic    store_d;
    logic    trial_en;
    logic    search_upd;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic search_end;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/cosine_similarity_unit.sv */
// Top level of the cosine similarity unit: controller plus datapath.
// Depends on csu_pkg, csu_ctrl and csu_datapath.
//
// Element pairs are taken one per cycle into the dot-product and
// sum-of-squares accumulators. After the pair marked last, the block stops
// accepting input for the ratio: two multiplies form the product of the
// squared norms and the squared dot product, then a search runs, each step
// a trial setup plus a multiply on the shared shift-add multiplier, and
// only then may the next vector start.
// The result register lets the next vector stream in while the previous result
// waits to be taken.
`default_nettype none

module cosine_similarity_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire csu_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output csu_pkg::out_t       out_data_o
);
  import csu_pkg::*;

  cmd_t    cmd;
  status_t status;

  csu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_element),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  csu_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

/* rtl/core/csu_mul.sv */
// Shift-add multiplier: one multiplier bit per cycle, 128-bit product.
// Depends on csu_pkg.
`default_nettype none

module csu_mul (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [csu_pkg::SqPW-1:0]   a_i,
  input  wire logic [csu_pkg::AccW-1:0]   b_i,
  output logic                            done_o,
  output logic [csu_pkg::ProdW-1:0]       prod_o
);
  import csu_pkg::*;

  localparam int unsigned CntW = $clog2(AccW);

  logic              busy_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic [ProdW-1:0]  acc_q, a_q;
  logic [AccW-1:0]   b_q;

  // Control: count the multiplier bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(AccW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: add the shifted multiplicand when the current bit is set
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= ProdW'(a_i);
      b_q   <= b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

/* rtl/core/csu_datapath.sv */
// Accumulators, ratio search registers and result register.
// Depends on csu_pkg and csu_mul.
`default_nettype none

module csu_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire csu_pkg::in_t    in_data_i,
  input  wire csu_pkg::cmd_t   cmd_i,
  output csu_pkg::status_t     status_o,
  output csu_pkg::out_t        out_data_o
);
  import csu_pkg::*;

  logic signed [AccW-1:0] dot_q;
  logic [AccW-1:0]        sq1_q, sq2_q;
  logic [AccW-1:0]        mag_q;
  logic                   neg_q, zero_q;
  logic [SqPW-1:0]        p_q;
  logic [ProdW-1:0]       rhs_q;
  logic [QW-1:0]          lo_q, hi_q;
  logic [MW-1:0]          m_q;
  out_t                   out_q;

  logic signed [2*ElemW-1:0] ab, aa, bb;
  logic signed [AccW:0]      dot_w;
  logic [AccW:0]             sq1_w, sq2_w;
  logic signed [AccW-1:0]    dot_d;
  logic [AccW-1:0]           sq1_d, sq2_d;
  logic [AccW-1:0]           mag_w;
  logic [QW:0]               q_w;
  logic [QW:0]               odd_w;
  logic [SqPW-1:0]           mul_a;
  logic [AccW-1:0]           mul_b;
  logic                      mul_done;
  logic [ProdW-1:0]          prod;
  logic [QW-1:0]             sim_mag;

  // Products of the incoming pair
  assign ab = in_data_i.first_element * in_data_i.second_element;
  assign aa = in_data_i.first_element * in_data_i.first_element;
  assign bb = in_data_i.second_element * in_data_i.second_element;

  // Add and saturate
  always_comb begin
    dot_w = (AccW+1)'(dot_q) + (AccW+1)'(ab);
    if (dot_w[AccW] != dot_w[AccW-1]) begin
      dot_d = dot_w[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      dot_d = dot_w[AccW-1:0];
    end
    sq1_w = {1'b0, sq1_q} + (AccW+1)'(unsigned'(aa));
    sq2_w = {1'b0, sq2_q} + (AccW+1)'(unsigned'(bb));
    sq1_d = sq1_w[AccW] ? {AccW{1'b1}} : sq1_w[AccW-1:0];
    sq2_d = sq2_w[AccW] ? {AccW{1'b1}} : sq2_w[AccW-1:0];
  end

  // Hold the sums; clear them once the result inputs are latched
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      sq1_q <= '0;
      sq2_q <= '0;
    end else if (cmd_i.latch) begin
      dot_q <= '0;
      sq1_q <= '0;
      sq2_q <= '0;
    end else if (cmd_i.acc_en) begin
      dot_q <= dot_d;
      sq1_q <= sq1_d;
      sq2_q <= sq2_d;
    end
  end

  assign mag_w = dot_q[AccW-1] ? AccW'(-dot_q) : AccW'(dot_q);

  // Trial value and its odd square
  assign q_w   = ({1'b0, lo_q} + {1'b0, hi_q} + 1'b1) >> 1;
  assign odd_w = {q_w[QW-1:0], 1'b0} - 1'b1;

  // Select multiplier operands
  always_comb begin
    case (cmd_i.mul_op)
      MUL_SQ_PROD: begin
        mul_a = SqPW'(sq1_q);
        mul_b = sq2_q;
      end
      MUL_DOT_SQ: begin
        mul_a = SqPW'(mag_q);
        mul_b = mag_q;
      end
      MUL_TRIAL: begin
        mul_a = p_q;
        mul_b = AccW'(m_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  csu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // Search registers and latched operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mag_q  <= mag_w;
      neg_q  <= dot_q[AccW-1];
      zero_q <= (sq1_q == '0) || (sq2_q == '0);
    end
    if (cmd_i.store_p) begin
      p_q <= prod[SqPW-1:0];
    end
    if (cmd_i.store_d) begin
      rhs_q <= prod << RoundSh;
      lo_q  <= '0;
      hi_q  <= QW'(SimOne);
    end
    if (cmd_i.trial_en) begin
      m_q <= MW'(odd_w[QW-1:0] * odd_w[QW-1:0]);
    end
    if (cmd_i.search_upd) begin
      if (prod <= rhs_q) begin
        lo_q <= q_w[QW-1:0];
      end else begin
        hi_q <= q_w[QW-1:0] - 1'b1;
      end
    end
    if (cmd_i.out_load) begin
      out_q.similarity <= neg_q ? -SimW'(sim_mag) : SimW'(sim_mag);
      out_q.zero_norm  <= zero_q;
    end
  end

  assign sim_mag = zero_q ? '0 : lo_q;

  assign status_o.mul_done   = mul_done;
  assign status_o.search_end = (lo_q >= hi_q);
  assign out_data_o          = out_q;

endmodule

`default_nettype wire

/* rtl/core/csu_ctrl.sv */
// Sequencer for accumulation, multiplies and the ratio search.
// Depends on csu_pkg.
`default_nettype none

module csu_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_last_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire csu_pkg::status_t  status_i,
  output csu_pkg::cmd_t          cmd_o
);
  import csu_pkg::*;

  typedef enum logic [7:0] {
    S_ACCUM  = 8'b0000_0001,
    S_LATCH  = 8'b0000_0010,
    S_MUL_P  = 8'b0000_0100,
    S_MUL_D  = 8'b0000_1000,
    S_TEST   = 8'b0001_0000,
    S_TRIAL  = 8'b0010_0000,
    S_MUL_M  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;

  assign in_ready_o = (state_q == S_ACCUM);
  assign in_fire    = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_op = MUL_SQ_PROD;
    cmd_o.acc_en = in_fire;
    case (state_q)
      S_ACCUM: begin
        if (in_fire && in_last_i) begin
          state_d = S_LATCH;
        end
      end
      S_LATCH: begin
        cmd_o.latch     = 1'b1;
        cmd_o.mul_start = 1'b1;
        state_d         = S_MUL_P;
      end
      S_MUL_P: begin
        cmd_o.mul_op = MUL_DOT_SQ;
        if (status_i.mul_done) begin
          cmd_o.store_p   = 1'b1;
          cmd_o.mul_start = 1'b1;
          state_d         = S_MUL_D;
        end
      end
      S_MUL_D: begin
        if (status_i.mul_done) begin
          cmd_o.store_d = 1'b1;
          state_d       = S_TEST;
        end
      end
      S_TEST: begin
        if (status_i.search_end) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.trial_en = 1'b1;
          state_d        = S_TRIAL;
        end
      end
      S_TRIAL: begin
        cmd_o.mul_op    = MUL_TRIAL;
        cmd_o.mul_start = 1'b1;
        state_d         = S_MUL_M;
      end
      S_MUL_M: begin
        if (status_i.mul_done) begin
          cmd_o.search_upd = 1'b1;
          state_d          = S_TEST;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_ACCUM;
        end
      end
      default: begin
        state_d = S_ACCUM;
      end
    endcase
  end

  // Hold the result until the transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACCUM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
